// File: rtl/lowpass_to_bandpass_tap_mixer_core_assert.svh
// ----------------------------------------------------------------------------
// Tap mixer assertion macros
// Same-cycle and next-cycle implication checks on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef LOWPASS_TO_BANDPASS_TAP_MIXER_CORE_ASSERT_SVH
`define LOWPASS_TO_BANDPASS_TAP_MIXER_CORE_ASSERT_SVH

`define LPBP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpbp same-cycle check failed");

`define LPBP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpbp next-cycle check failed");

`endif

// File: rtl/lpbp_pkg.sv
// ----------------------------------------------------------------------------
// lpbp_pkg
// Widths, CORDIC constants, shared types and rounding for the tap mixer.
// ----------------------------------------------------------------------------
package lpbp_pkg;

  localparam int SAMPLE_WIDTH  = 16;
  localparam int PHASE_WIDTH   = 32;
  localparam int CORDIC_STAGES = 16;

  localparam int TAP_W   = 16;
  localparam int STEP_W  = 32;
  localparam int ANGLE_W = 32;
  localparam int XY_W    = 34;
  localparam int Z_W     = 34;
  localparam int IDX_W   = 5;
  localparam int RND_W   = 36;

  localparam logic signed [XY_W-1:0] X_INIT = 34'sd652032874;

  localparam logic signed [RND_W-1:0] TRIG_HI = 36'sd32767;
  localparam logic signed [RND_W-1:0] TRIG_LO = -36'sd32768;
  localparam logic signed [RND_W-1:0] OUT_HI  = RND_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [RND_W-1:0] OUT_LO  = RND_W'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } lpbp_vec_t;

  typedef struct packed {
    logic signed [TAP_W-1:0] tap;
    logic                    flip;
    logic                    last;
  } lpbp_side_t;

  function automatic logic [ANGLE_W-1:0] atan_turns(input logic [IDX_W-1:0] idx);
    logic [ANGLE_W-1:0] a;
    case (idx)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      5'd20:   a = 32'h0000028C;
      5'd21:   a = 32'h00000146;
      5'd22:   a = 32'h000000A3;
      5'd23:   a = 32'h00000051;
      5'd24:   a = 32'h00000029;
      5'd25:   a = 32'h00000014;
      5'd26:   a = 32'h0000000A;
      5'd27:   a = 32'h00000005;
      5'd28:   a = 32'h00000003;
      5'd29:   a = 32'h00000001;
      5'd30:   a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

  // round half up at bit 15, floor shift, clamp
  function automatic logic signed [RND_W-1:0] rnd_sat(
    input logic signed [RND_W-1:0] v,
    input logic signed [RND_W-1:0] hi,
    input logic signed [RND_W-1:0] lo
  );
    logic signed [RND_W-1:0] r;
    r = (v + 36'sd16384) >>> 15;
    if (r > hi) begin
      r = hi;
    end else if (r < lo) begin
      r = lo;
    end
    return r;
  endfunction

endpackage

// File: rtl/lpbp_phase_front.sv
// ----------------------------------------------------------------------------
// lpbp_phase_front
// Phase accumulator, step latch and quadrant fold feeding the CORDIC row.
// ----------------------------------------------------------------------------
module lpbp_phase_front
  import lpbp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [TAP_W-1:0] in_tap_value,
  input  logic [STEP_W-1:0]       in_phase_step,
  input  logic                    in_first_tap,
  input  logic                    in_last_tap,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output lpbp_vec_t               dn_vec,
  output lpbp_side_t              dn_side
);

  logic [PHASE_WIDTH-1:0] acc_r, acc_nxt;
  logic [STEP_W-1:0]      held_r, held_nxt;
  logic                   valid_r, valid_nxt;
  lpbp_vec_t              vec_r, vec_nxt;
  lpbp_side_t             side_r, side_nxt;
  logic                   up_ready, take;
  logic [PHASE_WIDTH-1:0] acc_sel;
  logic [STEP_W-1:0]      step_sel;
  logic [ANGLE_W-1:0]     angle, angle_f;
  logic                   flip;

  assign up_ready = !valid_r || dn_ready;
  assign take     = in_valid && up_ready;
  assign in_stall = !up_ready;

  assign acc_sel  = in_first_tap ? '0 : acc_r;
  assign step_sel = in_first_tap ? in_phase_step : held_r;

  if (PHASE_WIDTH >= ANGLE_W) begin : g_wide
    assign angle = acc_sel[PHASE_WIDTH-1 -: ANGLE_W];
  end else begin : g_narrow
    assign angle = {acc_sel, {(ANGLE_W - PHASE_WIDTH){1'b0}}};
  end

  assign flip    = angle[ANGLE_W-1] ^ angle[ANGLE_W-2];
  assign angle_f = flip ? (angle ^ {1'b1, {(ANGLE_W - 1){1'b0}}}) : angle;

  always_comb begin
    acc_nxt   = acc_r;
    held_nxt  = held_r;
    valid_nxt = valid_r;
    vec_nxt   = vec_r;
    side_nxt  = side_r;
    if (dn_ready) begin
      valid_nxt = 1'b0;
    end
    if (take) begin
      acc_nxt       = acc_sel + PHASE_WIDTH'(step_sel);
      held_nxt      = step_sel;
      valid_nxt     = 1'b1;
      vec_nxt.x     = X_INIT;
      vec_nxt.y     = '0;
      vec_nxt.z     = Z_W'($signed(angle_f));
      side_nxt.tap  = in_tap_value;
      side_nxt.flip = flip;
      side_nxt.last = in_last_tap;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      held_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      held_r  <= held_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vec_r  <= vec_nxt;
    side_r <= side_nxt;
  end

  assign dn_valid = valid_r;
  assign dn_vec   = vec_r;
  assign dn_side  = side_r;

endmodule

// File: rtl/lpbp_cordic_cell.sv
// ----------------------------------------------------------------------------
// lpbp_cordic_cell
// One rotation-mode CORDIC iteration with its own word register.
// ----------------------------------------------------------------------------
module lpbp_cordic_cell
  import lpbp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] stage_idx,
  input  logic             up_valid,
  output logic             up_ready,
  input  lpbp_vec_t        up_vec,
  input  lpbp_side_t       up_side,
  output logic             dn_valid,
  input  logic             dn_ready,
  output lpbp_vec_t        dn_vec,
  output lpbp_side_t       dn_side
);

  logic                   valid_r;
  lpbp_vec_t              vec_r, vec_nxt;
  lpbp_side_t             side_r;
  logic signed [XY_W-1:0] dx, dy;
  logic signed [Z_W-1:0]  da;
  logic                   take;

  assign up_ready = !valid_r || dn_ready;
  assign take     = up_valid && up_ready;

  assign dx = up_vec.y >>> stage_idx;
  assign dy = up_vec.x >>> stage_idx;
  assign da = $signed({{(Z_W - ANGLE_W){1'b0}}, atan_turns(stage_idx)});

  always_comb begin
    if (!up_vec.z[Z_W-1]) begin
      vec_nxt.x = up_vec.x - dx;
      vec_nxt.y = up_vec.y + dy;
      vec_nxt.z = up_vec.z - da;
    end else begin
      vec_nxt.x = up_vec.x + dx;
      vec_nxt.y = up_vec.y - dy;
      vec_nxt.z = up_vec.z + da;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      vec_r  <= vec_nxt;
      side_r <= up_side;
    end
  end

  assign dn_valid = valid_r;
  assign dn_vec   = vec_r;
  assign dn_side  = side_r;

endmodule

// File: rtl/lpbp_mix_back.sv
// ----------------------------------------------------------------------------
// lpbp_mix_back
// Quadrant restore, Q1.15 trig rounding, tap products and output register.
// ----------------------------------------------------------------------------
module lpbp_mix_back
  import lpbp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  lpbp_vec_t               up_vec,
  input  lpbp_side_t              up_side,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [TAP_W-1:0] out_in_phase,
  output logic signed [TAP_W-1:0] out_quadrature,
  output logic                    out_end_of_filter
);

  localparam int PROD_W = 2 * TAP_W;

  logic                      va_r, vb_r, vc_r;
  logic                      ra, rb, rc;
  logic signed [TAP_W-1:0]   cos_r, sin_r, tap_a_r;
  logic                      last_a_r, last_b_r;
  logic signed [PROD_W-1:0]  pi_r, pq_r;
  logic signed [TAP_W-1:0]   oi_r, oq_r;
  logic                      ol_r;
  logic signed [RND_W-1:0]   xe, ye, xs, ys;

  assign rc = !vc_r || !out_stall;
  assign rb = !vb_r || rc;
  assign ra = !va_r || rb;
  assign up_ready = ra;

  assign xe = RND_W'(up_vec.x);
  assign ye = RND_W'(up_vec.y);
  assign xs = up_side.flip ? -xe : xe;
  assign ys = up_side.flip ? -ye : ye;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (ra) begin
        va_r <= up_valid;
      end
      if (rb) begin
        vb_r <= va_r;
      end
      if (rc) begin
        vc_r <= vb_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ra && up_valid) begin
      cos_r    <= TAP_W'(rnd_sat(xs, TRIG_HI, TRIG_LO));
      sin_r    <= TAP_W'(rnd_sat(ys, TRIG_HI, TRIG_LO));
      tap_a_r  <= up_side.tap;
      last_a_r <= up_side.last;
    end
    if (rb && va_r) begin
      pi_r     <= tap_a_r * cos_r;
      pq_r     <= tap_a_r * sin_r;
      last_b_r <= last_a_r;
    end
    if (rc && vb_r) begin
      oi_r <= TAP_W'(rnd_sat(RND_W'(pi_r), OUT_HI, OUT_LO));
      oq_r <= TAP_W'(rnd_sat(RND_W'(pq_r), OUT_HI, OUT_LO));
      ol_r <= last_b_r;
    end
  end

  assign out_valid         = vc_r;
  assign out_in_phase      = oi_r;
  assign out_quadrature    = oq_r;
  assign out_end_of_filter = ol_r;

endmodule

// File: rtl/lowpass_to_bandpass_tap_mixer_core.sv
// ----------------------------------------------------------------------------
// lowpass_to_bandpass_tap_mixer_core
// Mixes real lowpass taps with cos/sin of a running phase into bandpass taps.
//
//   channel | direction | handshake          | word
//   in_     | input     | in_valid/in_stall  | tap, phase step, first, last
//   out_    | output    | out_valid/out_stall| in-phase, quadrature, end flag
//
// One tap per cycle sustained while out_stall is low; each tap passes the phase
// front, one register per CORDIC cell, trig rounding, products and output.
// Every stage holds its word only while the next one is full and stalled,
// so empty stages keep taking words while a result waits at the output.
// Synchronous active-low reset clears the phase, the held step and all
// stage valids.
// ----------------------------------------------------------------------------
`include "lowpass_to_bandpass_tap_mixer_core_assert.svh"

module lowpass_to_bandpass_tap_mixer_core
  import lpbp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [TAP_W-1:0] in_tap_value,
  input  logic [STEP_W-1:0]       in_phase_step,
  input  logic                    in_first_tap,
  input  logic                    in_last_tap,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [TAP_W-1:0] out_in_phase,
  output logic signed [TAP_W-1:0] out_quadrature,
  output logic                    out_end_of_filter
);

  logic       vld  [CORDIC_STAGES+1];
  logic       rdy  [CORDIC_STAGES+1];
  lpbp_vec_t  vec  [CORDIC_STAGES+1];
  lpbp_side_t side [CORDIC_STAGES+1];

  lpbp_phase_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_tap_value (in_tap_value),
    .in_phase_step(in_phase_step),
    .in_first_tap (in_first_tap),
    .in_last_tap  (in_last_tap),
    .dn_valid     (vld[0]),
    .dn_ready     (rdy[0]),
    .dn_vec       (vec[0]),
    .dn_side      (side[0])
  );

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    lpbp_cordic_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .stage_idx(IDX_W'(k)),
      .up_valid (vld[k]),
      .up_ready (rdy[k]),
      .up_vec   (vec[k]),
      .up_side  (side[k]),
      .dn_valid (vld[k+1]),
      .dn_ready (rdy[k+1]),
      .dn_vec   (vec[k+1]),
      .dn_side  (side[k+1])
    );
  end

  lpbp_mix_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .up_valid         (vld[CORDIC_STAGES]),
    .up_ready         (rdy[CORDIC_STAGES]),
    .up_vec           (vec[CORDIC_STAGES]),
    .up_side          (side[CORDIC_STAGES]),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_in_phase     (out_in_phase),
    .out_quadrature   (out_quadrature),
    .out_end_of_filter(out_end_of_filter)
  );

  `LPBP_ASSERT_NOW(a_ready_chain, !out_stall, !in_stall)
  `LPBP_ASSERT_NEXT(a_front_hold, vld[0] && !rdy[0], vld[0] && $stable(side[0]))
  `LPBP_ASSERT_NEXT(a_row_end_hold, vld[CORDIC_STAGES] && !rdy[CORDIC_STAGES],
                    vld[CORDIC_STAGES] && $stable(vec[CORDIC_STAGES]))

endmodule
